// ===== sv/polar_angle_histogram_assert.svh =====
// Assertion macros for the polar angle histogram checker.
// Depends on nothing; included by the checker file.
`ifndef POLAR_ANGLE_HISTOGRAM_ASSERT_SVH
`define POLAR_ANGLE_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PAH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram assertion failed");

// Next-cycle implication, disabled during reset.
`define PAH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram assertion failed");

`endif

// ===== sv/pah_pkg.sv =====
// Shared types and constants for the polar angle histogram.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps

package pah_pkg;

  localparam int MaxSectors = 64;
  localparam int TallyBits  = 16;
  localparam int AngleBits  = 16;
  localparam int SecBits    = 6;
  localparam int CountBits  = 7;
  localparam int FracBits   = 44;  // fraction bits of turns and coordinates
  localparam int NumIter    = 44;  // rotation steps
  localparam int IterBits   = 6;
  localparam int DatBits    = 63;  // signed coordinate width during rotation
  localparam int ZBits      = 47;  // signed angle accumulator width

  // Turns per radian.
  localparam real InvTwoPi = 1.0 / (2.0 * 3.14159265358979323846);

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic               final_point;
  } point_t;

  typedef struct packed {
    logic [5:0]  sector_index;
    logic [15:0] sector_tally;
    logic [15:0] largest_tally;
    logic        last_sector;
  } result_t;

  typedef logic [FracBits-1:0] atan_lut_t [NumIter];

  // atan(2^-i) in turns, with FracBits fraction bits, worked out at elaboration.
  function automatic atan_lut_t atan_lut_build();
    atan_lut_t lut;
    real       r;
    for (int i = 0; i < NumIter; i++) begin
      r = $atan(2.0 ** (-i)) * InvTwoPi;
      lut[i] = FracBits'(longint'(r * (2.0 ** FracBits)));
    end
    return lut;
  endfunction

  localparam atan_lut_t AtanLut = atan_lut_build();

endpackage

// ===== sv/polar_angle_histogram.sv =====
// Polar angle histogram: operation. A point is accepted, then takes
// 44 rotation steps of a shared shift-add angle unit, then angle rounding,
// sector multiply, and a read and write of the tally memory. A point marked
// final then adds a scan of the sectors in use for the largest tally,
// emission of one result per sector in use, held by any output stall, and
// a pass that clears the whole tally memory. The input
// is stalled throughout; configuration writes are taken at any time.
// Holds the datapath and tally memory; depends on pah_pkg.
`timescale 1ns / 1ps

module polar_angle_histogram import pah_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  point_t       in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output result_t      out_data,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ROT      = 4'd1;
  localparam logic [3:0] S_ANG      = 4'd2;
  localparam logic [3:0] S_SECT     = 4'd3;
  localparam logic [3:0] S_RD       = 4'd4;
  localparam logic [3:0] S_WR       = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_CMP = 4'd7;
  localparam logic [3:0] S_EMIT_RD  = 4'd8;
  localparam logic [3:0] S_EMIT_LD  = 4'd9;
  localparam logic [3:0] S_EMIT_WT  = 4'd10;
  localparam logic [3:0] S_CLEAR    = 4'd11;

  localparam logic signed [ZBits-1:0] TurnQuarter = ZBits'(64'd1 << (FracBits - 2));
  localparam logic signed [ZBits-1:0] TurnHalf    = ZBits'(64'd1 << (FracBits - 1));
  localparam logic signed [ZBits-1:0] TurnFull    = ZBits'(64'd1 << FracBits);
  localparam logic signed [ZBits-1:0] RoundHalf   =
    ZBits'(64'd1 << (FracBits - 1 - AngleBits));

  logic [3:0]                 state_r, state_nxt;
  logic signed [DatBits-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [ZBits-1:0]    z_r, z_nxt;
  logic [IterBits-1:0]        it_r, it_nxt;
  logic                       swap_r, swap_nxt, xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic                       orig_r, orig_nxt, final_r, final_nxt;
  logic [AngleBits-1:0]       ba_r, ba_nxt;
  logic [SecBits-1:0]         sec_r, sec_nxt;
  logic [CountBits-1:0]       idx_r, idx_nxt;
  logic [TallyBits-1:0]       largest_r, largest_nxt;
  logic [CountBits-1:0]       nsec_r, nsec_nxt;
  result_t                    out_data_r, out_data_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Tally memory: one write port, one registered read port.
  logic [TallyBits-1:0]       tally_mem [MaxSectors];
  logic [TallyBits-1:0]       rdata_r;
  logic [SecBits-1:0]         raddr, waddr;
  logic                       we;
  logic [TallyBits-1:0]       wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      tally_mem[waddr] <= wdata;
    end
    rdata_r <= tally_mem[raddr];
  end

  // Working values for the input fold and angle rounding.
  logic [16:0]                ax, ay;
  logic signed [ZBits-1:0]    phi, theta;
  logic [AngleBits+CountBits-1:0] prod;
  logic [CountBits-1:0]       idx_inc;
  logic signed [DatBits-1:0]  xs, ys;

  assign ax = in_data.x_coord[15] ? 17'(-{1'b1, in_data.x_coord}) : {1'b0, in_data.x_coord};
  assign ay = in_data.y_coord[15] ? 17'(-{1'b1, in_data.y_coord}) : {1'b0, in_data.y_coord};
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign idx_inc = idx_r + 1'b1;
  assign prod = {{CountBits{1'b0}}, ba_r} * {{AngleBits{1'b0}}, nsec_r};

  always_comb begin
    phi = swap_r ? (TurnQuarter - z_r) : z_r;
    if (xneg_r && !yneg_r) begin
      theta = TurnHalf - phi;
    end else if (xneg_r) begin
      theta = TurnHalf + phi;
    end else if (yneg_r) begin
      theta = TurnFull - phi;
    end else begin
      theta = phi;
    end
    theta = theta + RoundHalf;
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt    = state_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    it_nxt       = it_r;
    swap_nxt     = swap_r;
    xneg_nxt     = xneg_r;
    yneg_nxt     = yneg_r;
    orig_nxt     = orig_r;
    final_nxt    = final_r;
    ba_nxt       = ba_r;
    sec_nxt      = sec_r;
    idx_nxt      = idx_r;
    largest_nxt  = largest_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r;
    raddr        = sec_r;
    waddr        = sec_r;
    we           = 1'b0;
    wdata        = rdata_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          xneg_nxt  = in_data.x_coord[15];
          yneg_nxt  = in_data.y_coord[15];
          orig_nxt  = (ax == 17'd0) && (ay == 17'd0);
          final_nxt = in_data.final_point;
          swap_nxt  = ay > ax;
          x_nxt     = (ay > ax) ? DatBits'({ay, {FracBits{1'b0}}})
                                : DatBits'({ax, {FracBits{1'b0}}});
          y_nxt     = (ay > ax) ? DatBits'({ax, {FracBits{1'b0}}})
                                : DatBits'({ay, {FracBits{1'b0}}});
          z_nxt     = '0;
          it_nxt    = '0;
          state_nxt = S_ROT;
        end
      end
      // One vectoring step per cycle drives y toward zero.
      S_ROT: begin
        if (!y_r[DatBits-1]) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + ZBits'(AtanLut[it_r]);
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - ZBits'(AtanLut[it_r]);
        end
        it_nxt = it_r + 1'b1;
        if (it_r == IterBits'(NumIter - 1)) begin
          state_nxt = S_ANG;
        end
      end
      S_ANG: begin
        ba_nxt    = orig_r ? '0 : theta[FracBits-1 -: AngleBits];
        state_nxt = S_SECT;
      end
      S_SECT: begin
        sec_nxt   = prod[AngleBits +: SecBits];
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      // Saturating increment written back to the same entry.
      S_WR: begin
        we    = 1'b1;
        wdata = (rdata_r == {TallyBits{1'b1}}) ? rdata_r : rdata_r + 1'b1;
        idx_nxt     = '0;
        largest_nxt = '0;
        state_nxt   = final_r ? S_SCAN_RD : S_IDLE;
      end
      S_SCAN_RD: begin
        raddr     = idx_r[SecBits-1:0];
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (rdata_r > largest_r) begin
          largest_nxt = rdata_r;
        end
        if (idx_inc == nsec_r) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN_RD;
        end
      end
      S_EMIT_RD: begin
        raddr     = idx_r[SecBits-1:0];
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_data_nxt.sector_index  = idx_r[SecBits-1:0];
        out_data_nxt.sector_tally  = rdata_r;
        out_data_nxt.largest_tally = largest_r;
        out_data_nxt.last_sector   = idx_inc == nsec_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT_WT;
      end
      // Hold the beat until the receiver takes it.
      S_EMIT_WT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (idx_inc == nsec_r) begin
            idx_nxt   = '0;
            state_nxt = S_CLEAR;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      // Zero every entry, including sectors beyond the count in use.
      S_CLEAR: begin
        we      = 1'b1;
        waddr   = idx_r[SecBits-1:0];
        wdata   = '0;
        idx_nxt = idx_inc;
        if (idx_r == CountBits'(MaxSectors - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sector count register with clamping to 1..MaxSectors.
  always_comb begin
    nsec_nxt = nsec_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        nsec_nxt = CountBits'(1);
      end else if (cfg_wdata > CountBits'(MaxSectors)) begin
        nsec_nxt = CountBits'(MaxSectors);
      end else begin
        nsec_nxt = cfg_wdata;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      nsec_r      <= CountBits'(8);
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      nsec_r      <= nsec_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    it_r       <= it_nxt;
    swap_r     <= swap_nxt;
    xneg_r     <= xneg_nxt;
    yneg_r     <= yneg_nxt;
    orig_r     <= orig_nxt;
    final_r    <= final_nxt;
    ba_r       <= ba_nxt;
    sec_r      <= sec_nxt;
    largest_r  <= largest_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/pah_checker.sv =====
// Port-level checks for the polar angle histogram, bound to the top level.
// Depends on pah_pkg and polar_angle_histogram_assert.svh.
`timescale 1ns / 1ps
`include "polar_angle_histogram_assert.svh"

module pah_checker import pah_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_stall,
  input point_t  in_data,
  input logic    out_valid,
  input logic    out_stall,
  input result_t out_data,
  input logic    cfg_we,
  input logic [6:0] cfg_wdata
);

  // A stalled result beat holds.
  `PAH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // Each accepted point keeps the block busy in the next cycle.
  `PAH_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // No point is taken while results are being emitted.
  `PAH_ASSERT_NOW(a_no_accept_emit, clk, rst_n, out_valid, in_stall)
  // A sector never exceeds the largest tally reported with it.
  `PAH_ASSERT_NOW(a_tally_le_max, clk, rst_n, out_valid, out_data.sector_tally <= out_data.largest_tally)
  // After the last sector's beat the output goes quiet.
  `PAH_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && !out_stall && out_data.last_sector, !out_valid)

endmodule

bind polar_angle_histogram pah_checker u_pah_checker (.*);
